/* rtl/core/lgs_pkg.sv */
// ============================================================================
// lgs_pkg - shared types and constants of the LDA topic sampler
// Configuration register map, count helpers and fixed-point limits.
// ============================================================================
package lgs_pkg;

    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 24;
    localparam int WORD_W  = 12;
    localparam int DOC_W   = 10;
    localparam int TOPIC_W = 6;
    localparam int RAND_W  = 32;
    localparam int NTOP_W  = 7;
    localparam int DIV_RW  = 50;

    typedef enum logic [CFG_IW-1:0] {
        REG_ALPHA      = 2'd0,
        REG_BETA       = 2'd1,
        REG_NUM_TOPICS = 2'd2,
        REG_VOCAB_SIZE = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [23:0] alpha_q16;
        logic [23:0] beta_q16;
        logic [6:0]  num_topics;
        logic [12:0] vocab_size;
    } cfg_t;

    localparam logic [23:0] ALPHA_RST = 24'd65536;
    localparam logic [23:0] BETA_RST  = 24'd6554;
    localparam logic [6:0]  NTOP_RST  = 7'd64;
    localparam logic [12:0] VOCAB_RST = 13'd4096;

    localparam logic KIND_INIT     = 1'b0;
    localparam logic KIND_RESAMPLE = 1'b1;

    localparam logic [52:0] WEIGHT_CAP = '1;
    localparam logic [31:0] RATIO_SAT  = 32'hFFFF_FFFF;
    localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;

    // saturating counter step: up stops at all ones, down stops at zero
    function automatic logic [31:0] count_step(input logic [31:0] c, input logic up);
        logic [31:0] r;
        r = c;
        if (up)
        begin
            if (c != COUNT_MAX)
                r = c + 32'd1;
        end
        else
        begin
            if (c != 32'd0)
                r = c - 32'd1;
        end
        return r;
    endfunction

endpackage

/* rtl/core/lgs_front.sv */
// ============================================================================
// lgs_front - token intake
// Accepts a token, folds word and document indices into the store ranges
// and hands a packed command to the queue.
// ============================================================================
module lgs_front #(
    parameter int  MAX_WORDS = 4096,
    parameter int  MAX_DOCS  = 1024,
    localparam int WA        = $clog2(MAX_WORDS),
    localparam int DA        = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1,
    localparam int CMD_W     = 1 + WA + DA + 6 + 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             enable,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,
    input  logic [0:0]       s_tuser,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output logic [CMD_W-1:0] cmd_data
);
    import lgs_pkg::*;

    // index mod constant by reciprocal multiply; exact for these widths
    localparam int WREC = (MAX_WORDS >= 4096) ? 1 : ((1 << 24) + MAX_WORDS - 1) / MAX_WORDS;
    localparam int DREC = (MAX_DOCS >= 1024) ? 1 : ((1 << 20) + MAX_DOCS - 1) / MAX_DOCS;

    typedef enum logic [1:0] {F_IDLE, F_REDUCE, F_PUSH} fstate_t;

    fstate_t           state_reg, state_next;
    logic              kind_reg, kind_next;
    logic [11:0]       wraw_reg, wraw_next;
    logic [9:0]        draw_reg, draw_next;
    logic [5:0]        old_reg, old_next;
    logic [31:0]       rnd_reg, rnd_next;
    logic [12:0]       wq_reg, wq_next;
    logic [10:0]       dq_reg, dq_next;
    logic [WA-1:0]     widx_reg, widx_next;
    logic [DA-1:0]     didx_reg, didx_next;
    logic [36:0]       wprod;
    logic [30:0]       dprod;

    assign wprod = 37'(s_tdata[11:0]) * 37'(WREC);
    assign dprod = 31'(s_tdata[21:12]) * 31'(DREC);

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        wraw_next  = wraw_reg;
        draw_next  = draw_reg;
        old_next   = old_reg;
        rnd_next   = rnd_reg;
        wq_next    = wq_reg;
        dq_next    = dq_reg;
        widx_next  = widx_reg;
        didx_next  = didx_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    kind_next  = s_tuser[0];
                    wraw_next  = s_tdata[11:0];
                    draw_next  = s_tdata[21:12];
                    old_next   = s_tdata[27:22];
                    rnd_next   = s_tdata[59:28];
                    wq_next    = wprod[36:24];
                    dq_next    = dprod[30:20];
                    state_next = F_REDUCE;
                end
            end
            F_REDUCE:
            begin
                widx_next  = WA'(32'(wraw_reg) - 32'(wq_reg) * 32'(MAX_WORDS));
                didx_next  = DA'(32'(draw_reg) - 32'(dq_reg) * 32'(MAX_DOCS));
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (cmd_ready)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        wraw_reg <= wraw_next;
        draw_reg <= draw_next;
        old_reg  <= old_next;
        rnd_reg  <= rnd_next;
        wq_reg   <= wq_next;
        dq_reg   <= dq_next;
        widx_reg <= widx_next;
        didx_reg <= didx_next;
    end

    assign s_tready  = enable && (state_reg == F_IDLE);
    assign cmd_valid = (state_reg == F_PUSH);
    assign cmd_data  = {kind_reg, widx_reg, didx_reg, old_reg, rnd_reg};

endmodule

/* rtl/core/lgs_fifo.sv */
// ============================================================================
// lgs_fifo - command queue
// Short first-in first-out queue between intake and sampling engine.
// ============================================================================
module lgs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_reg, wr_next;
    logic [PW-1:0]    rd_reg, rd_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready  = (cnt_reg != CW'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = slot_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        if (pop)
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CW'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= in_data;
    end

endmodule

/* rtl/core/lgs_div.sv */
// ============================================================================
// lgs_div - bit-serial restoring divider
// One quotient bit per cycle; serves both the word ratio
// and the initial topic remainder.
// ============================================================================
module lgs_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [lgs_pkg::DIV_RW-1:0] init_rem,
    input  logic [31:0]               init_dsr,
    input  logic [lgs_pkg::DIV_RW-1:0] den,
    output logic                      done,
    output logic [31:0]               quo,
    output logic [lgs_pkg::DIV_RW-1:0] rem
);
    import lgs_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [DIV_RW-1:0] rem_reg, rem_next;
    logic [DIV_RW-1:0] den_reg, den_next;
    logic [31:0]       dsr_reg, dsr_next;
    logic [31:0]       quo_reg, quo_next;
    logic [DIV_RW:0]   sh;

    assign sh = {rem_reg, dsr_reg[31]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = init_rem;
            den_next  = den;
            dsr_next  = init_dsr;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            dsr_next = {dsr_reg[30:0], 1'b0};
            if (sh >= {1'b0, den_reg})
            begin
                rem_next = DIV_RW'(sh - {1'b0, den_reg});
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = sh[DIV_RW-1:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

/* rtl/core/lgs_back.sv */
// ============================================================================
// lgs_back - sampling engine
// Owns the count stores, runs the per-topic weights, the cumulative search
// and the count updates, and holds the result register.
// ============================================================================
module lgs_back #(
    parameter int  MAX_TOPICS = 64,
    parameter int  MAX_WORDS  = 4096,
    parameter int  MAX_DOCS   = 1024,
    localparam int WA         = $clog2(MAX_WORDS),
    localparam int DA         = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1,
    localparam int CMD_W      = 1 + WA + DA + 6 + 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  lgs_pkg::cfg_t    cfg,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  logic [CMD_W-1:0] cmd_data,
    output logic             clearing,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata
);
    import lgs_pkg::*;

    localparam int TA        = $clog2(MAX_TOPICS);
    localparam int WT_DEPTH  = MAX_WORDS * MAX_TOPICS;
    localparam int DT_DEPTH  = MAX_DOCS * MAX_TOPICS;
    localparam int WTA       = $clog2(WT_DEPTH);
    localparam int DTA       = $clog2(DT_DEPTH);
    localparam int CLR_DEPTH = (WT_DEPTH > DT_DEPTH)
                               ? ((WT_DEPTH > MAX_DOCS) ? WT_DEPTH : MAX_DOCS)
                               : ((DT_DEPTH > MAX_DOCS) ? DT_DEPTH : MAX_DOCS);
    localparam int CLRW      = $clog2(CLR_DEPTH);

    typedef enum logic [4:0] {
        B_CLEAR, B_IDLE, B_RD, B_WR, B_MOD, B_WRD, B_WSET, B_WDIV, B_MLO, B_MHI,
        B_WGT, B_ACC, B_ULO, B_UHI, B_USUM, B_SRD, B_SCMP, B_DONE
    } bstate_t;

    // count stores and cumulative weights
    logic [31:0] wt_mem   [WT_DEPTH];
    logic [31:0] dt_mem   [DT_DEPTH];
    logic [31:0] tt_mem   [MAX_TOPICS];
    logic [31:0] dtot_mem [MAX_DOCS];
    logic [63:0] cum_mem  [MAX_TOPICS];

    bstate_t        state_reg, state_next;
    logic [CLRW-1:0] clr_reg, clr_next;
    logic [WTA-1:0] wbase_reg, wbase_next;
    logic [DTA-1:0] dbase_reg, dbase_next;
    logic [DA-1:0]  didx_reg, didx_next;
    logic [31:0]    rnd_reg, rnd_next;
    logic [6:0]     kact_reg, kact_next;
    logic [6:0]     k_reg, k_next;
    logic [6:0]     t_reg, t_next;
    logic           up_reg, up_next;
    logic [36:0]    vbeta_reg, vbeta_next;
    logic [48:0]    f_reg, f_next;
    logic [31:0]    r_reg, r_next;
    logic [63:0]    lo_reg, lo_next;
    logic [63:0]    prod_reg, prod_next;
    logic [52:0]    wgt_reg, wgt_next;
    logic [63:0]    total_reg, total_next;
    logic [63:0]    u_reg, u_next;
    logic           out_valid_reg, out_valid_next;
    logic [5:0]     out_topic_reg, out_topic_next;

    // command fields
    logic           c_kind;
    logic [WA-1:0]  c_widx;
    logic [DA-1:0]  c_didx;
    logic [5:0]     c_old;
    logic [31:0]    c_rnd;
    logic [6:0]     kclamp;

    // memory ports
    logic [6:0]     tsel;
    logic [WTA-1:0] wt_a;
    logic [DTA-1:0] dt_a;
    logic [TA-1:0]  tt_a;
    logic           wt_we, dt_we, tt_we, dtot_we, cum_we;
    logic [WTA-1:0] wt_wa;
    logic [DTA-1:0] dt_wa;
    logic [TA-1:0]  tt_wa;
    logic [DA-1:0]  dtot_wa;
    logic [31:0]    wt_wd, dt_wd, tt_wd, dtot_wd;
    logic [31:0]    wt_q, dt_q, tt_q, dtot_q;
    logic [63:0]    cum_q;

    // arithmetic
    logic [DIV_RW-1:0] num_w, den_w;
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       mul_p;
    logic [53:0]       wsum;
    logic [52:0]       wgt_c;

    // divider
    logic              div_start, div_done;
    logic [DIV_RW-1:0] div_rem_init, div_den, div_rem;
    logic [31:0]       div_dsr_init, div_quo;

    assign {c_kind, c_widx, c_didx, c_old, c_rnd} = cmd_data;

    always_comb
    begin
        if (cfg.num_topics == 7'd0)
            kclamp = 7'd1;
        else if (32'(cfg.num_topics) > MAX_TOPICS)
            kclamp = 7'(MAX_TOPICS);
        else
            kclamp = cfg.num_topics;
    end

    assign tsel  = (state_reg == B_WRD) ? k_reg : t_reg;
    assign wt_a  = wbase_reg + WTA'(tsel);
    assign dt_a  = dbase_reg + DTA'(tsel);
    assign tt_a  = TA'(tsel);

    assign num_w = DIV_RW'({wt_q, 16'h0000}) + DIV_RW'(cfg.beta_q16);
    assign den_w = DIV_RW'({tt_q, 16'h0000}) + DIV_RW'(vbeta_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            B_MLO:
            begin
                mul_a = r_reg;
                mul_b = f_reg[31:0];
            end
            B_MHI:
            begin
                mul_a = r_reg;
                mul_b = 32'(f_reg[48:32]);
            end
            B_ULO:
            begin
                mul_a = rnd_reg;
                mul_b = total_reg[31:0];
            end
            B_UHI:
            begin
                mul_a = rnd_reg;
                mul_b = total_reg[63:32];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // weight = r*f / 2^16 from the two partial products, capped
    assign wsum = 54'({prod_reg[36:0], 16'h0000}) + 54'(lo_reg[63:16]);
    always_comb
    begin
        if (|prod_reg[63:37])
            wgt_c = WEIGHT_CAP;
        else if (wsum > 54'(WEIGHT_CAP))
            wgt_c = WEIGHT_CAP;
        else
            wgt_c = wsum[52:0];
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_rem_init = '0;
        div_dsr_init = '0;
        div_den      = '0;
        if (state_reg == B_IDLE)
        begin
            div_start    = cmd_valid && (c_kind == KIND_INIT);
            div_dsr_init = c_rnd;
            div_den      = DIV_RW'(kclamp);
        end
        else if (state_reg == B_WSET)
        begin
            div_start    = (num_w < den_w);
            div_rem_init = num_w;
            div_den      = den_w;
        end
    end

    lgs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .init_rem (div_rem_init),
        .init_dsr (div_dsr_init),
        .den      (div_den),
        .done     (div_done),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    // store write ports: clearing sweep or count update
    always_comb
    begin
        wt_we   = 1'b0;
        dt_we   = 1'b0;
        tt_we   = 1'b0;
        dtot_we = 1'b0;
        wt_wa   = wt_a;
        dt_wa   = dt_a;
        tt_wa   = tt_a;
        dtot_wa = didx_reg;
        wt_wd   = count_step(wt_q, up_reg);
        dt_wd   = count_step(dt_q, up_reg);
        tt_wd   = count_step(tt_q, up_reg);
        dtot_wd = count_step(dtot_q, up_reg);
        case (state_reg)
            B_CLEAR:
            begin
                wt_we   = (32'(clr_reg) < WT_DEPTH);
                dt_we   = (32'(clr_reg) < DT_DEPTH);
                tt_we   = (32'(clr_reg) < MAX_TOPICS);
                dtot_we = (32'(clr_reg) < MAX_DOCS);
                wt_wa   = WTA'(clr_reg);
                dt_wa   = DTA'(clr_reg);
                tt_wa   = TA'(clr_reg);
                dtot_wa = DA'(clr_reg);
                wt_wd   = '0;
                dt_wd   = '0;
                tt_wd   = '0;
                dtot_wd = '0;
            end
            B_WR:
            begin
                wt_we   = 1'b1;
                dt_we   = 1'b1;
                tt_we   = 1'b1;
                dtot_we = 1'b1;
            end
            default:
            begin
                wt_we = 1'b0;
            end
        endcase
    end

    assign cum_we = (state_reg == B_ACC);

    always_ff @(posedge clk)
    begin
        if (wt_we)
            wt_mem[wt_wa] <= wt_wd;
        wt_q <= wt_mem[wt_a];
    end

    always_ff @(posedge clk)
    begin
        if (dt_we)
            dt_mem[dt_wa] <= dt_wd;
        dt_q <= dt_mem[dt_a];
    end

    always_ff @(posedge clk)
    begin
        if (tt_we)
            tt_mem[tt_wa] <= tt_wd;
        tt_q <= tt_mem[tt_a];
    end

    always_ff @(posedge clk)
    begin
        if (dtot_we)
            dtot_mem[dtot_wa] <= dtot_wd;
        dtot_q <= dtot_mem[didx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cum_we)
            cum_mem[TA'(k_reg)] <= total_next;
        cum_q <= cum_mem[TA'(k_reg)];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        wbase_next     = wbase_reg;
        dbase_next     = dbase_reg;
        didx_next      = didx_reg;
        rnd_next       = rnd_reg;
        kact_next      = kact_reg;
        k_next         = k_reg;
        t_next         = t_reg;
        up_next        = up_reg;
        vbeta_next     = vbeta_reg;
        f_next         = f_reg;
        r_next         = r_reg;
        lo_next        = lo_reg;
        prod_next      = prod_reg;
        wgt_next       = wgt_reg;
        total_next     = total_reg;
        u_next         = u_reg;
        out_valid_next = out_valid_reg;
        out_topic_next = out_topic_reg;
        cmd_ready      = 1'b0;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            B_CLEAR:
            begin
                clr_next = clr_reg + CLRW'(1);
                if (clr_reg == CLRW'(CLR_DEPTH - 1))
                    state_next = B_IDLE;
            end
            B_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    wbase_next = WTA'(32'(c_widx) * 32'(MAX_TOPICS));
                    dbase_next = DTA'(32'(c_didx) * 32'(MAX_TOPICS));
                    didx_next  = c_didx;
                    rnd_next   = c_rnd;
                    kact_next  = kclamp;
                    vbeta_next = 37'(cfg.vocab_size) * 37'(cfg.beta_q16);
                    k_next     = '0;
                    total_next = '0;
                    if (c_kind == KIND_INIT)
                        state_next = B_MOD;
                    else if (7'(c_old) < kclamp)
                    begin
                        t_next     = 7'(c_old);
                        up_next    = 1'b0;
                        state_next = B_RD;
                    end
                    else
                        state_next = B_WRD;
                end
            end
            B_MOD:
            begin
                if (div_done)
                begin
                    t_next     = div_rem[6:0];
                    up_next    = 1'b1;
                    state_next = B_RD;
                end
            end
            B_RD:
            begin
                state_next = B_WR;
            end
            B_WR:
            begin
                if (up_reg)
                    state_next = B_DONE;
                else
                begin
                    k_next     = '0;
                    total_next = '0;
                    state_next = B_WRD;
                end
            end
            B_WRD:
            begin
                state_next = B_WSET;
            end
            B_WSET:
            begin
                f_next = 49'({dt_q, 16'h0000}) + 49'(cfg.alpha_q16);
                if (num_w >= den_w)
                begin
                    r_next     = RATIO_SAT;
                    state_next = B_MLO;
                end
                else
                    state_next = B_WDIV;
            end
            B_WDIV:
            begin
                if (div_done)
                begin
                    r_next     = div_quo;
                    state_next = B_MLO;
                end
            end
            B_MLO:
            begin
                lo_next    = mul_p;
                state_next = B_MHI;
            end
            B_MHI:
            begin
                prod_next  = mul_p;
                state_next = B_WGT;
            end
            B_WGT:
            begin
                wgt_next   = wgt_c;
                state_next = B_ACC;
            end
            B_ACC:
            begin
                total_next = total_reg + 64'(wgt_reg);
                if (k_reg == kact_reg - 7'd1)
                begin
                    if (total_next == 64'd0)
                    begin
                        t_next     = kact_reg - 7'd1;
                        up_next    = 1'b1;
                        state_next = B_RD;
                    end
                    else
                        state_next = B_ULO;
                end
                else
                begin
                    k_next     = k_reg + 7'd1;
                    state_next = B_WRD;
                end
            end
            B_ULO:
            begin
                lo_next    = mul_p;
                state_next = B_UHI;
            end
            B_UHI:
            begin
                prod_next  = mul_p;
                state_next = B_USUM;
            end
            B_USUM:
            begin
                u_next     = prod_reg + 64'(lo_reg[63:32]) + 64'd1;
                k_next     = '0;
                state_next = B_SRD;
            end
            B_SRD:
            begin
                state_next = B_SCMP;
            end
            B_SCMP:
            begin
                if ((cum_q >= u_reg) || (k_reg == kact_reg - 7'd1))
                begin
                    t_next     = k_reg;
                    up_next    = 1'b1;
                    state_next = B_RD;
                end
                else
                begin
                    k_next     = k_reg + 7'd1;
                    state_next = B_SRD;
                end
            end
            B_DONE:
            begin
                // hold until the result register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_topic_next = t_reg[5:0];
                    state_next     = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wbase_reg     <= wbase_next;
        dbase_reg     <= dbase_next;
        didx_reg      <= didx_next;
        rnd_reg       <= rnd_next;
        kact_reg      <= kact_next;
        k_reg         <= k_next;
        t_reg         <= t_next;
        up_reg        <= up_next;
        vbeta_reg     <= vbeta_next;
        f_reg         <= f_next;
        r_reg         <= r_next;
        lo_reg        <= lo_next;
        prod_reg      <= prod_next;
        wgt_reg       <= wgt_next;
        total_reg     <= total_next;
        u_reg         <= u_next;
        out_topic_reg <= out_topic_next;
    end

    assign clearing = (state_reg == B_CLEAR);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_topic_reg};

endmodule

/* rtl/core/lda_gibbs_topic_sampler.sv */
// ============================================================================
// lda_gibbs_topic_sampler - collapsed Gibbs topic sampler
// Token intake, command queue, sampling engine and configuration registers.
// ============================================================================
// After reset the block sweeps its count stores to zero over
// max(MAX_WORDS*MAX_TOPICS, MAX_DOCS*MAX_TOPICS, MAX_DOCS) addresses (262144 with
// the default sizes) and takes no token until the sweep ends; configuration
// writes are taken throughout. One token is sampled at a time. An initial
// assignment is set by the serial remainder of the random value by the active
// topic count K. A resample sends each active topic's word ratio through the
// one-bit-per-cycle divider (skipped when the ratio saturates) and adds the
// cumulative search, the count read-modify-write, draw scaling and handoff.
// The intake and a two-entry queue take up to three further tokens while the
// engine works, and a finished result waits in its own output register.
module lda_gibbs_topic_sampler #(
    parameter int MAX_TOPICS = 64,
    parameter int MAX_WORDS  = 4096,
    parameter int MAX_DOCS   = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [63:0]               s_tdata,   // word_index, doc_index, old_topic, random_value
    input  logic [0:0]                s_tuser,   // kind
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,   // new_topic
    input  logic                      cfg_we,
    input  logic [lgs_pkg::CFG_IW-1:0] cfg_index,
    input  logic [lgs_pkg::CFG_DW-1:0] cfg_wdata
);
    import lgs_pkg::*;

    localparam int WA    = $clog2(MAX_WORDS);
    localparam int DA    = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
    localparam int CMD_W = 1 + WA + DA + 6 + 32;

    cfg_t             cfg_reg;
    logic             clearing;
    logic             f_valid, f_ready;
    logic [CMD_W-1:0] f_data;
    logic             q_valid, q_ready;
    logic [CMD_W-1:0] q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha_q16  <= ALPHA_RST;
            cfg_reg.beta_q16   <= BETA_RST;
            cfg_reg.num_topics <= NTOP_RST;
            cfg_reg.vocab_size <= VOCAB_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ALPHA:      cfg_reg.alpha_q16  <= cfg_wdata;
                REG_BETA:       cfg_reg.beta_q16   <= cfg_wdata;
                REG_NUM_TOPICS: cfg_reg.num_topics <= cfg_wdata[6:0];
                REG_VOCAB_SIZE: cfg_reg.vocab_size <= cfg_wdata[12:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    lgs_front #(
        .MAX_WORDS (MAX_WORDS),
        .MAX_DOCS  (MAX_DOCS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (!clearing),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_data  (f_data)
    );

    lgs_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    lgs_back #(
        .MAX_TOPICS (MAX_TOPICS),
        .MAX_WORDS  (MAX_WORDS),
        .MAX_DOCS   (MAX_DOCS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd_data  (q_data),
        .clearing  (clearing),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* rtl/core/lgs_checker.sv */
// ============================================================================
// lgs_checker - port-level checks of the topic sampler
// Tracks tokens in flight and watches the result channel.
// ============================================================================
module lgs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    logic [3:0] pend_reg, pend_next;
    logic       in_acc, out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_acc && !out_acc)
            pend_next = pend_reg + 4'd1;
        else if (out_acc && !in_acc)
            pend_next = pend_reg - 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    // every result answers an earlier token
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (pend_reg != 4'd0))
        else $error("result transaction without a pending token");

    // intake, queue, engine and output register hold at most five tokens
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 4'd5)
        else $error("too many tokens in flight");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result valid dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result data changed while stalled");

endmodule

bind lda_gibbs_topic_sampler lgs_checker u_lgs_checker (.*);
